@@ design/contour_bounding_box_pad_clamp_macros.svh @@
// ----------------------------------------------------------------------------
// Contour bounding box assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CONTOUR_BOUNDING_BOX_PAD_CLAMP_MACROS_SVH
`define CONTOUR_BOUNDING_BOX_PAD_CLAMP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CBBPC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CBBPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/cbbpc_pkg.sv @@
// ----------------------------------------------------------------------------
// Contour bounding box package
// Shared types, codes and defaults of the bounding box block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbbpc_pkg;

   localparam int COORD_W          = 17;  // signed Q12.4 point coordinate
   localparam int BOX_W            = 16;  // unsigned Q12.4 box coordinate
   localparam int CFG_W            = 12;
   localparam int CSR_INDEX_W      = 2;
   localparam int ACTION_W         = 2;
   localparam int STATUS_W         = 2;
   localparam int REQ_DATA_W       = 40;  // two coordinates, padded to bytes
   localparam int RSP_DATA_W       = 64;

   localparam int COORD_FRAC_BITS_DEFAULT  = 4;
   localparam int FACTOR_FRAC_BITS_DEFAULT = 8;
   localparam int QUEUE_DEPTH_DEFAULT      = 2;

   localparam logic [CFG_W-1:0] BUFFER_FACTOR_RESET = 12'd0;
   localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET   = 12'd640;
   localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET  = 12'd480;

   localparam logic [ACTION_W-1:0] ACT_ADD        = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD_FINISH = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FINISH     = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_BUFFER_FACTOR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_EMPTY      = 2'd1,
      STATUS_DEGENERATE = 2'd2
   } status_type;

   // One finished contour, classified, handed from front to back.
   typedef struct packed {
      status_type                 status;
      logic signed [COORD_W-1:0]  lo_x;
      logic signed [COORD_W-1:0]  hi_x;
      logic signed [COORD_W-1:0]  lo_y;
      logic signed [COORD_W-1:0]  hi_y;
   } job_type;

endpackage : cbbpc_pkg

`default_nettype wire

@@ design/cbbpc_front.sv @@
// ----------------------------------------------------------------------------
// Contour bounding box front end
// Accept points, track running extremes, classify each finished contour.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbbpc_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [cbbpc_pkg::ACTION_W-1:0]      action,
   input  logic signed [cbbpc_pkg::COORD_W-1:0] point_x,
   input  logic signed [cbbpc_pkg::COORD_W-1:0] point_y,
   output logic                                push,
   output cbbpc_pkg::job_type                  push_job,
   output logic                                have_point
);
   import cbbpc_pkg::*;

   logic signed [COORD_W-1:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic signed [COORD_W-1:0] min_x_in, max_x_in, min_y_in, max_y_in;
   logic                      have_ff, have_in;
   logic                      is_add, is_fin, have_after;
   logic signed [COORD_W-1:0] upd_min_x, upd_max_x, upd_min_y, upd_max_y;
   logic signed [COORD_W-1:0] end_min_x, end_max_x, end_min_y, end_max_y;

   assign is_add = (action == ACT_ADD) || (action == ACT_ADD_FINISH);
   assign is_fin = (action == ACT_ADD_FINISH) || (action == ACT_FINISH);

   always_comb begin
      // first point of a contour seeds all extremes
      upd_min_x = (!have_ff || point_x < min_x_ff) ? point_x : min_x_ff;
      upd_max_x = (!have_ff || point_x > max_x_ff) ? point_x : max_x_ff;
      upd_min_y = (!have_ff || point_y < min_y_ff) ? point_y : min_y_ff;
      upd_max_y = (!have_ff || point_y > max_y_ff) ? point_y : max_y_ff;
      end_min_x = is_add ? upd_min_x : min_x_ff;
      end_max_x = is_add ? upd_max_x : max_x_ff;
      end_min_y = is_add ? upd_min_y : min_y_ff;
      end_max_y = is_add ? upd_max_y : max_y_ff;
      have_after = have_ff | is_add;

      push_job.lo_x = end_min_x;
      push_job.hi_x = end_max_x;
      push_job.lo_y = end_min_y;
      push_job.hi_y = end_max_y;
      if (!have_after) begin
         push_job.status = STATUS_EMPTY;
      end else if (end_max_x <= end_min_x || end_max_y <= end_min_y) begin
         push_job.status = STATUS_DEGENERATE;
      end else begin
         push_job.status = STATUS_OK;
      end
      push = accept && is_fin;

      min_x_in = min_x_ff;
      max_x_in = max_x_ff;
      min_y_in = min_y_ff;
      max_y_in = max_y_ff;
      have_in  = have_ff;
      if (accept && is_fin) begin
         // clear the accumulator after every result
         min_x_in = '0;
         max_x_in = '0;
         min_y_in = '0;
         max_y_in = '0;
         have_in  = 1'b0;
      end else if (accept && is_add) begin
         min_x_in = upd_min_x;
         max_x_in = upd_max_x;
         min_y_in = upd_min_y;
         max_y_in = upd_max_y;
         have_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff <= '0;
         max_x_ff <= '0;
         min_y_ff <= '0;
         max_y_ff <= '0;
         have_ff  <= 1'b0;
      end else begin
         min_x_ff <= min_x_in;
         max_x_ff <= max_x_in;
         min_y_ff <= min_y_in;
         max_y_ff <= max_y_in;
         have_ff  <= have_in;
      end
   end

   assign have_point = have_ff;

endmodule : cbbpc_front

`default_nettype wire

@@ design/cbbpc_queue.sv @@
// ----------------------------------------------------------------------------
// Contour bounding box job queue
// Small FIFO of classified contours between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbbpc_queue #(
   parameter int DEPTH = cbbpc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cbbpc_pkg::job_type push_job,
   output logic               full,
   input  logic               pop,
   output logic               valid,
   output cbbpc_pkg::job_type pop_job
);
   import cbbpc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign valid   = (count_ff != '0);
   assign pop_job = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule : cbbpc_queue

`default_nettype wire

@@ design/cbbpc_back.sv @@
// ----------------------------------------------------------------------------
// Contour bounding box back end
// Scale the box about its center, clamp to the image, hold the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbbpc_back #(
   parameter int COORD_FRAC_BITS  = cbbpc_pkg::COORD_FRAC_BITS_DEFAULT,
   parameter int FACTOR_FRAC_BITS = cbbpc_pkg::FACTOR_FRAC_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [cbbpc_pkg::CFG_W-1:0]       buffer_factor,
   input  logic [cbbpc_pkg::CFG_W-1:0]       image_width,
   input  logic [cbbpc_pkg::CFG_W-1:0]       image_height,
   input  logic                              job_valid,
   input  cbbpc_pkg::job_type                job,
   output logic                              job_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cbbpc_pkg::BOX_W-1:0]       box_left,
   output logic [cbbpc_pkg::BOX_W-1:0]       box_top,
   output logic [cbbpc_pkg::BOX_W-1:0]       box_right,
   output logic [cbbpc_pkg::BOX_W-1:0]       box_bottom,
   output cbbpc_pkg::status_type             status
);
   import cbbpc_pkg::*;

   localparam int SPAN_W = COORD_W + 1;           // hi - lo, as signed
   localparam int FAC_W  = CFG_W + 2;             // factor minus one, signed
   localparam int PROD_W = SPAN_W + FAC_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int LIM_W  = BOX_W + COORD_FRAC_BITS;

   function automatic logic [BOX_W-1:0] clamp_box(
      input logic signed [SUM_W-1:0] v,
      input logic [BOX_W-1:0]        lim
   );
      logic signed [SUM_W-1:0] lim_s;
      lim_s = signed'(SUM_W'(lim));
      if (v < 0) begin
         clamp_box = '0;
      end else if (v > lim_s) begin
         clamp_box = lim;
      end else begin
         clamp_box = v[BOX_W-1:0];
      end
   endfunction

   function automatic logic [BOX_W-1:0] limit_of(input logic [CFG_W-1:0] size);
      logic [LIM_W-1:0] wide;
      wide = LIM_W'(size) << COORD_FRAC_BITS;
      if (32'(wide) > 32'(16'hFFFF)) begin
         limit_of = 16'hFFFF;
      end else begin
         limit_of = wide[BOX_W-1:0];
      end
   endfunction

   logic                     advance;
   logic                     s1_valid_ff;
   job_type                  s1_job_ff;
   logic signed [PROD_W-1:0] s1_prod_x_ff, s1_prod_y_ff;
   logic signed [PROD_W-1:0] prod_x_in, prod_y_in;
   logic signed [SPAN_W-1:0] span_x, span_y;
   logic signed [FAC_W-1:0]  delta;

   logic                     rsp_valid_ff;
   logic [BOX_W-1:0]         left_ff, top_ff, right_ff, bottom_ff;
   logic [BOX_W-1:0]         left_in, top_in, right_in, bottom_in;
   status_type               status_ff;
   logic signed [PROD_W-1:0] pad_x, pad_y;
   logic signed [SUM_W-1:0]  lo_x_pad, hi_x_pad, lo_y_pad, hi_y_pad;
   logic [BOX_W-1:0]         lim_x, lim_y;

   // stall the whole back end only while a result waits and is not taken
   assign advance = !rsp_valid_ff || rsp_ready;
   assign job_pop = advance && job_valid;

   // stage 1: span times (factor - 1.0), zero factor means no padding
   always_comb begin
      span_x = signed'(SPAN_W'(job.hi_x)) - signed'(SPAN_W'(job.lo_x));
      span_y = signed'(SPAN_W'(job.hi_y)) - signed'(SPAN_W'(job.lo_y));
      if (buffer_factor == '0) begin
         delta = '0;
      end else begin
         delta = signed'(FAC_W'(buffer_factor)) - signed'(FAC_W'(1) << FACTOR_FRAC_BITS);
      end
      prod_x_in = span_x * delta;
      prod_y_in = span_y * delta;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= job_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_job_ff    <= job;
         s1_prod_x_ff <= prod_x_in;
         s1_prod_y_ff <= prod_y_in;
      end
   end

   // stage 2: halve with floor, widen the box, clamp to the image
   always_comb begin
      pad_x    = s1_prod_x_ff >>> (FACTOR_FRAC_BITS + 1);
      pad_y    = s1_prod_y_ff >>> (FACTOR_FRAC_BITS + 1);
      lo_x_pad = SUM_W'(s1_job_ff.lo_x) - SUM_W'(pad_x);
      hi_x_pad = SUM_W'(s1_job_ff.hi_x) + SUM_W'(pad_x);
      lo_y_pad = SUM_W'(s1_job_ff.lo_y) - SUM_W'(pad_y);
      hi_y_pad = SUM_W'(s1_job_ff.hi_y) + SUM_W'(pad_y);
      lim_x    = limit_of(image_width);
      lim_y    = limit_of(image_height);
      if (s1_job_ff.status == STATUS_OK) begin
         left_in   = clamp_box(lo_x_pad, lim_x);
         top_in    = clamp_box(lo_y_pad, lim_y);
         right_in  = clamp_box(hi_x_pad, lim_x);
         bottom_in = clamp_box(hi_y_pad, lim_y);
      end else begin
         left_in   = '0;
         top_in    = '0;
         right_in  = '0;
         bottom_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         left_ff   <= left_in;
         top_ff    <= top_in;
         right_ff  <= right_in;
         bottom_ff <= bottom_in;
         status_ff <= s1_job_ff.status;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign box_left   = left_ff;
   assign box_top    = top_ff;
   assign box_right  = right_ff;
   assign box_bottom = bottom_ff;
   assign status     = status_ff;

endmodule : cbbpc_back

`default_nettype wire

@@ design/contour_bounding_box_pad_clamp.sv @@
// ----------------------------------------------------------------------------
// Contour bounding box with padding and clamping
// Streams contour points in, streams one clamped box out per contour.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries contour points. tuser holds the action: add a point, add a
//   point and finish, or finish without a point (code 3 is accepted and
//   dropped). req transactions are taken back to back while the job queue has room.
//   rsp_* carries one box per finished contour: tdata holds left, top,
//   right, bottom (unsigned Q12.4), tuser holds the status (valid box, empty
//   contour, degenerate box); error results carry an all-zero box.
//   csr_* writes buffer_factor, image_width and image_height; write them only
//   while no contour is in flight. csr_ready is always high.
// Path: a finishing transaction is written into the job queue, then registered
//   by the multiply stage, then clamped into the output register that drives
//   rsp_tvalid.
// Throughput: one transaction per cycle on each side while neither side stalls;
//   the running min/max update and the one 18 x 14 multiply per axis each fit in one stage.
// Reset: clears the accumulator, the job queue and the output stage, and
//   loads factor 0, width 640 and height 480.
// Stall: while a result waits and rsp_tready is low the back end holds; the queue
//   keeps taking finished contours until it fills, then req_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module contour_bounding_box_pad_clamp #(
   parameter int COORD_FRAC_BITS  = cbbpc_pkg::COORD_FRAC_BITS_DEFAULT,
   parameter int FACTOR_FRAC_BITS = cbbpc_pkg::FACTOR_FRAC_BITS_DEFAULT,
   parameter int QUEUE_DEPTH      = cbbpc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input points
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [cbbpc_pkg::REQ_DATA_W-1:0]     req_tdata,  // point_x, point_y, zero pad
   input  logic [cbbpc_pkg::ACTION_W-1:0]       req_tuser,  // action
   // output boxes
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [cbbpc_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // box_left, box_top, box_right, box_bottom
   output logic [cbbpc_pkg::STATUS_W-1:0]       rsp_tuser,  // status
   // configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cbbpc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cbbpc_pkg::CFG_W-1:0]          csr_data
);
   import cbbpc_pkg::*;

   `include "contour_bounding_box_pad_clamp_macros.svh"

   logic [CFG_W-1:0]          buffer_factor_ff, image_width_ff, image_height_ff;
   logic [CFG_W-1:0]          buffer_factor_in, image_width_in, image_height_in;
   logic                      req_accept;
   logic                      front_push;
   job_type                   front_job;
   logic                      front_have;
   logic                      queue_full;
   logic                      queue_valid;
   job_type                   queue_job;
   logic                      queue_pop;
   logic [BOX_W-1:0]          box_left, box_top, box_right, box_bottom;
   status_type                box_status;

   // ---------------------------------------------------------------------
   // Configuration registers: always ready, unknown indexes dropped
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      buffer_factor_in = buffer_factor_ff;
      image_width_in   = image_width_ff;
      image_height_in  = image_height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BUFFER_FACTOR: buffer_factor_in = csr_data;
            CSR_IMAGE_WIDTH:   image_width_in   = csr_data;
            CSR_IMAGE_HEIGHT:  image_height_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_factor_ff <= BUFFER_FACTOR_RESET;
         image_width_ff   <= IMAGE_WIDTH_RESET;
         image_height_ff  <= IMAGE_HEIGHT_RESET;
      end else begin
         buffer_factor_ff <= buffer_factor_in;
         image_width_ff   <= image_width_in;
         image_height_ff  <= image_height_in;
      end
   end

   // ---------------------------------------------------------------------
   // Front: accept points as long as the job queue has room
   // ---------------------------------------------------------------------
   assign req_tready = !queue_full;
   assign req_accept = req_tvalid && req_tready;

   cbbpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .action     (req_tuser),
      .point_x    (signed'(req_tdata[COORD_W-1:0])),
      .point_y    (signed'(req_tdata[2*COORD_W-1:COORD_W])),
      .push       (front_push),
      .push_job   (front_job),
      .have_point (front_have)
   );

   cbbpc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .push_job (front_job),
      .full     (queue_full),
      .pop      (queue_pop),
      .valid    (queue_valid),
      .pop_job  (queue_job)
   );

   // ---------------------------------------------------------------------
   // Back: pad, clamp and hold the result for the receiver
   // ---------------------------------------------------------------------
   cbbpc_back #(
      .COORD_FRAC_BITS  (COORD_FRAC_BITS),
      .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .buffer_factor (buffer_factor_ff),
      .image_width   (image_width_ff),
      .image_height  (image_height_ff),
      .job_valid     (queue_valid),
      .job           (queue_job),
      .job_pop       (queue_pop),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .box_left      (box_left),
      .box_top       (box_top),
      .box_right     (box_right),
      .box_bottom    (box_bottom),
      .status        (box_status)
   );

   assign rsp_tdata = {box_bottom, box_right, box_top, box_left};
   assign rsp_tuser = box_status;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // error results carry an all-zero box
   `CBBPC_ASSERT_IMP(a_error_box_zero, clock, reset,
      rsp_tvalid && (rsp_tuser != STATUS_OK), rsp_tdata == '0,
      "error result with nonzero box")

   // a plain add point never produces a job
   `CBBPC_ASSERT_IMP(a_add_no_job, clock, reset,
      req_accept && (req_tuser == ACT_ADD), !front_push,
      "add point pushed a job")

   // a finishing transaction leaves the accumulator empty
   `CBBPC_ASSERT_NEXT(a_finish_clears, clock, reset,
      req_accept && ((req_tuser == ACT_ADD_FINISH) || (req_tuser == ACT_FINISH)),
      !front_have,
      "accumulator not cleared after finish")

endmodule : contour_bounding_box_pad_clamp

`default_nettype wire

@@ tb/tb_contour_bounding_box_pad_clamp.sv @@
// ----------------------------------------------------------------------------
// Contour bounding box testbench
// Streams directed and random contours into the block under several register
// settings and checks every box against a cycle-free prediction of the
// running min/max, the padding about the center and the clamp to the image.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_contour_bounding_box_pad_clamp;
   import cbbpc_pkg::*;

   typedef struct packed {
      logic [BOX_W-1:0] left;
      logic [BOX_W-1:0] top;
      logic [BOX_W-1:0] right;
      logic [BOX_W-1:0] bottom;
      status_type       status;
   } box_result_type;

   class box_scoreboard;
      logic [CFG_W-1:0] factor_q48;
      logic [CFG_W-1:0] width_px;
      logic [CFG_W-1:0] height_px;
      longint           min_x, max_x, min_y, max_y;
      bit               have_point;
      box_result_type   expected_boxes[$];
      int               mismatches;
      int               checked;
      int               per_status[3];

      function new();
         factor_q48 = BUFFER_FACTOR_RESET;
         width_px   = IMAGE_WIDTH_RESET;
         height_px  = IMAGE_HEIGHT_RESET;
         have_point = 0;
      endfunction

      function void note_csr(logic [CSR_INDEX_W-1:0] index, logic [CFG_W-1:0] value);
         case (index)
            CSR_BUFFER_FACTOR: factor_q48 = value;
            CSR_IMAGE_WIDTH:   width_px   = value;
            CSR_IMAGE_HEIGHT:  height_px  = value;
            default: ;
         endcase
      endfunction

      function longint image_limit(logic [CFG_W-1:0] size);
         longint lim;
         lim = longint'(size) << COORD_FRAC_BITS_DEFAULT;
         return (lim > 65535) ? 65535 : lim;
      endfunction

      function logic [BOX_W-1:0] clamp_box(longint v, longint lim);
         if (v < 0) return '0;
         if (v > lim) return BOX_W'(lim);
         return BOX_W'(v);
      endfunction

      // Fold one accepted point transaction into the running box; on a finish,
      // queue the box that the block must produce.
      function void note_point(logic [ACTION_W-1:0] action,
                               logic signed [COORD_W-1:0] px,
                               logic signed [COORD_W-1:0] py);
         box_result_type exp;
         longint         lo_x, hi_x, lo_y, hi_y, d, pad_x, pad_y;
         if (action != ACT_ADD && action != ACT_ADD_FINISH && action != ACT_FINISH) return;
         if (action != ACT_FINISH) begin
            if (!have_point) begin
               min_x = px; max_x = px; min_y = py; max_y = py;
            end else begin
               if (px < min_x) min_x = px;
               if (px > max_x) max_x = px;
               if (py < min_y) min_y = py;
               if (py > max_y) max_y = py;
            end
            have_point = 1;
            if (action == ACT_ADD) return;
         end
         exp = '0;
         if (!have_point) begin
            exp.status = STATUS_EMPTY;
         end else if (max_x <= min_x || max_y <= min_y) begin
            exp.status = STATUS_DEGENERATE;
         end else begin
            lo_x = min_x; hi_x = max_x; lo_y = min_y; hi_y = max_y;
            if (factor_q48 != 0) begin
               // floor division: arithmetic shift of a signed product
               d     = longint'(factor_q48) - (longint'(1) << FACTOR_FRAC_BITS_DEFAULT);
               pad_x = ((hi_x - lo_x) * d) >>> (FACTOR_FRAC_BITS_DEFAULT + 1);
               pad_y = ((hi_y - lo_y) * d) >>> (FACTOR_FRAC_BITS_DEFAULT + 1);
               lo_x -= pad_x; hi_x += pad_x;
               lo_y -= pad_y; hi_y += pad_y;
            end
            exp.left   = clamp_box(lo_x, image_limit(width_px));
            exp.right  = clamp_box(hi_x, image_limit(width_px));
            exp.top    = clamp_box(lo_y, image_limit(height_px));
            exp.bottom = clamp_box(hi_y, image_limit(height_px));
            exp.status = STATUS_OK;
         end
         expected_boxes.push_back(exp);
         have_point = 0;
         min_x = 0; max_x = 0; min_y = 0; max_y = 0;
      endfunction

      function void compare_field(string name, longint exp_val, longint got_val);
         if (exp_val != got_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, got_val);
            mismatches++;
         end
      endfunction

      function void check_box(logic [RSP_DATA_W-1:0] tdata, logic [STATUS_W-1:0] tuser);
         box_result_type exp;
         if (expected_boxes.size() == 0) begin
            $error("box transaction with no box pending: tdata %h, tuser %0d", tdata, tuser);
            mismatches++;
            return;
         end
         exp = expected_boxes.pop_front();
         compare_field("box_left",   exp.left,   tdata[15:0]);
         compare_field("box_top",    exp.top,    tdata[31:16]);
         compare_field("box_right",  exp.right,  tdata[47:32]);
         compare_field("box_bottom", exp.bottom, tdata[63:48]);
         compare_field("status",     exp.status, tuser);
         checked++;
         if (exp.status <= STATUS_DEGENERATE) per_status[exp.status]++;
      endfunction

      function int pending();
         return expected_boxes.size();
      endfunction
   endclass

   localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;  // accepted and dropped
   localparam int NUM_PHASES      = 10;
   localparam int ITEMS_PER_PHASE = 68;
   localparam int SETTLE_CYCLES   = 8;       // idle time after the last box returns
   localparam int HOLD_CYCLES     = 300;
   localparam int LIMIT_CYCLES    = 400000;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_W-1:0]    req_tdata;    // point_x, point_y, zero pad
   logic [ACTION_W-1:0]      req_tuser;    // action
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_W-1:0]    rsp_tdata;    // box_left, box_top, box_right, box_bottom
   logic [STATUS_W-1:0]      rsp_tuser;    // status
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index;
   logic [CFG_W-1:0]         csr_data;

   box_scoreboard sb = new();

   bit gaps_on;          // random idling on both sides
   int hold_request;     // receiver hold-off length, picked up by the receiver
   int cycle_count;
   int points_sent;
   int items_sent;
   int settings_used;

   contour_bounding_box_pad_clamp i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("contour_bounding_box_pad_clamp verification failed");
         $finish;
      end
   end

   // Box receiver: check every accepted transaction, then pick the next ready.
   // A hold-off request is counted down here while the
   // sender keeps offering points so the job queue fills and req_tready drops.
   initial begin : box_receiver
      int hold_left;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_box(rsp_tdata, rsp_tuser);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(gaps_on && $urandom_range(0, 99) < 11);
         end
      end
   end

   // Offer one point transaction and hold it until accepted.
   task automatic send_item(logic [ACTION_W-1:0] action,
                            logic signed [COORD_W-1:0] px,
                            logic signed [COORD_W-1:0] py);
      if (gaps_on) begin
         while ($urandom_range(0, 99) < 11) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {{(REQ_DATA_W - 2*COORD_W){1'b0}}, py, px};
      do @(posedge clock); while (!req_tready);
      sb.note_point(action, px, py);
      if (action != ACT_IGNORED) items_sent++;
      if (action == ACT_ADD || action == ACT_ADD_FINISH) points_sent++;
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.note_csr(index, value);
   endtask

   // Drop valid and wait until every pending box has come back, then settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly near the image, sometimes anywhere in the 17-bit range.
   function automatic logic signed [COORD_W-1:0] rand_coord(logic [CFG_W-1:0] size);
      if ($urandom_range(0, 4) == 0) return COORD_W'($urandom);
      return COORD_W'(int'($urandom_range(0, int'(size) * 16 + 256)) - 128);
   endfunction

   function automatic int rand_span();
      if ($urandom_range(0, 9) == 0) return 0;
      return $urandom_range(1, ($urandom_range(0, 7) == 0) ? 70000 : 1500);
   endfunction

   // One well-formed contour: n points inside a random window, closed either
   // by the last point or by a separate finish.
   task automatic send_contour(int n_points, bit finish_alone);
      int bx, by, bw, bh, k;
      logic [ACTION_W-1:0] act;
      bx = rand_coord(sb.width_px);
      by = rand_coord(sb.height_px);
      bw = rand_span();
      bh = rand_span();
      for (k = 0; k < n_points; k++) begin
         act = (k == n_points - 1 && !finish_alone) ? ACT_ADD_FINISH : ACT_ADD;
         send_item(act, COORD_W'(bx + int'($urandom_range(0, bw))),
                        COORD_W'(by + int'($urandom_range(0, bh))));
      end
      if (finish_alone) send_item(ACT_FINISH, COORD_W'($urandom), COORD_W'($urandom));
   endtask

   initial begin : stimulus
      int phase, phase_start, pick;
      logic [CFG_W-1:0] f, w, h;
      bit paused;

      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= ACT_ADD;
      csr_valid   <= 1'b0;
      csr_index   <= CSR_BUFFER_FACTOR;
      csr_data    <= '0;
      gaps_on      = 1'b1;
      hold_request = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed contours under the reset settings (no padding, 640 x 480).
      send_item(ACT_FINISH,     17'h00000, 17'h00000);  // empty contour
      send_item(ACT_ADD_FINISH, 17'h00005, 17'h00005);  // single point
      send_item(ACT_ADD,        17'h10000, 17'h10000);  // most negative corner
      send_item(ACT_ADD_FINISH, 17'h0FFFF, 17'h0FFFF);  // most positive corner
      send_item(ACT_ADD,        17'h00010, 17'h00050);
      send_item(ACT_ADD_FINISH, 17'h00010, 17'h00320);  // zero width
      send_item(ACT_ADD,        17'h00064, 17'h0012C);
      send_item(ACT_ADD_FINISH, 17'h00384, 17'h0012C);  // zero height
      send_item(ACT_IGNORED,    17'h1FFFF, 17'h1FFFF);  // must not touch state
      send_item(ACT_ADD,        17'h000A0, 17'h000A0);
      send_item(ACT_IGNORED,    17'h00000, 17'h00000);
      send_item(ACT_ADD,        17'h0AAAA, 17'h15555);
      send_item(ACT_FINISH,     17'h15555, 17'h0AAAA);
      send_item(ACT_ADD,        17'h00000, 17'h00000);
      send_item(ACT_ADD_FINISH, 17'h027FF, 17'h01DFF);  // just inside the image
      send_item(ACT_ADD,        17'h02800, 17'h01E00);
      send_item(ACT_ADD_FINISH, 17'h02801, 17'h01E01);  // just past the image
      wait_idle();
      settings_used = 1;

      for (phase = 1; phase <= NUM_PHASES; phase++) begin
         case (phase)
            1: begin f = 12'd512;  w = 12'd640;  h = 12'd480;  end  // double size
            2: begin f = 12'd1;    w = 12'd0;    h = 12'd0;    end  // near-full shrink, no image
            3: begin f = 12'd4095; w = 12'd4095; h = 12'd4095; end  // largest everything
            4: begin f = 12'd128;  w = 12'd1;    h = 12'd4095; end
            5: begin f = 12'd256;  w = 12'd320;  h = 12'd240;  end  // unit factor
            default: begin
               pick = $urandom_range(0, 3);
               f = (pick == 0) ? 12'd0 : CFG_W'($urandom);
               w = CFG_W'($urandom_range(1, 4095));
               h = CFG_W'($urandom_range(1, 4095));
            end
         endcase
         // Run one phase with no idling at all on either side.
         gaps_on = (phase != 1);
         write_csr(CSR_BUFFER_FACTOR, f);
         write_csr(CSR_IMAGE_WIDTH,   w);
         write_csr(CSR_IMAGE_HEIGHT,  h);
         csr_valid <= 1'b0;
         settings_used++;
         if (phase == 4) hold_request = HOLD_CYCLES;
         paused      = 1'b0;
         phase_start = items_sent;
         while (items_sent - phase_start < ITEMS_PER_PHASE) begin
            // Halfway through one phase, pause until every box is back.
            if (phase == 5 && !paused && items_sent - phase_start >= ITEMS_PER_PHASE / 2) begin
               paused = 1'b1;
               req_tvalid <= 1'b0;
               do @(posedge clock); while (sb.pending() != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 85)
               send_contour(($urandom_range(0, 19) == 0) ? $urandom_range(9, 40)
                                                         : $urandom_range(1, 8),
                            $urandom_range(0, 2) == 0);
            else if (pick < 90)
               send_item(ACT_IGNORED, COORD_W'($urandom), COORD_W'($urandom));
            else if (pick < 95)
               send_item(ACT_FINISH, COORD_W'($urandom), COORD_W'($urandom));
            else
               // stray point that merges into the next contour
               send_item(ACT_ADD, rand_coord(sb.width_px), rand_coord(sb.height_px));
         end
         // Close any open contour before the settings change.
         send_item(ACT_FINISH, COORD_W'($urandom), COORD_W'($urandom));
         wait_idle();
      end

      $display("Sent %0d point transactions (%0d points) across %0d register settings.",
               items_sent, points_sent, settings_used);
      $display("Checked %0d boxes: %0d valid, %0d empty, %0d degenerate.",
               sb.checked, sb.per_status[STATUS_OK], sb.per_status[STATUS_EMPTY],
               sb.per_status[STATUS_DEGENERATE]);
      if (sb.mismatches == 0)
         $display("contour_bounding_box_pad_clamp verification clean");
      else
         $display("contour_bounding_box_pad_clamp verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/cbbpc_pkg.sv
design/cbbpc_front.sv
design/cbbpc_queue.sv
design/cbbpc_back.sv
design/contour_bounding_box_pad_clamp.sv
tb/tb_contour_bounding_box_pad_clamp.sv
